// ===== hdl/bts_pkg.sv =====
// bilinear texture sampler: shared types, constants and per-axis helper functions
// no dependencies
`default_nettype none
package bts_pkg;

  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HEIGHT      = 256;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = 24;
  localparam int SIZE_W          = 9;
  localparam int IDX_W           = 8;
  localparam int ADDR_W          = 16;
  localparam int TEX_DEPTH       = MAX_WIDTH * MAX_HEIGHT;
  localparam int OPND_W          = COORD_FRAC_BITS + 1;
  localparam int POS_W           = OPND_W + SIZE_W;

  localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1 << COORD_FRAC_BITS);

  localparam logic [1:0] WRAP_TILE  = 2'd0;
  localparam logic [1:0] WRAP_TRANS = 2'd2;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_LAYER    = 3'd2;
  localparam logic [2:0] REG_FALLBACK = 3'd3;
  localparam logic [2:0] REG_CHANNELS = 3'd4;

  localparam logic [2:0] CHANNELS_RGB = 3'd3;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SAMPLE,
    KIND_HIDDEN,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] x0;
    logic [IDX_W-1:0] x1;
    logic [IDX_W-1:0] y0;
    logic [IDX_W-1:0] y1;
    logic [7:0]       fx;
    logic [7:0]       fy;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]      wdata;
  } fetch_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  fx;
    logic [7:0]  fy;
    logic [31:0] t00;
    logic [31:0] t10;
    logic [31:0] t01;
    logic [31:0] t11;
  } blend_item_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    begin
      if (s == '0) r = SIZE_W'(1);
      else if (s > maxv) r = maxv;
      else r = s;
      return r;
    end
  endfunction

  // repeat keeps the fraction only: floor(frac*size) is already the wrapped index
  function automatic logic [OPND_W-1:0] axis_operand(input logic signed [COORD_W-1:0] c,
                                                     input logic [1:0] mode);
    logic [OPND_W-1:0] r;
    begin
      if (mode == WRAP_TILE) r = {1'b0, c[COORD_FRAC_BITS-1:0]};
      else if (c[COORD_W-1]) r = '0;
      else if (c > COORD_ONE) r = OPND_W'(COORD_ONE);
      else r = c[OPND_W-1:0];
      return r;
    end
  endfunction

  function automatic logic outside_unit(input logic signed [COORD_W-1:0] c,
                                        input logic [1:0] mode);
    return (mode == WRAP_TRANS) && (c[COORD_W-1] || (c > COORD_ONE));
  endfunction

  // returns {i0, i1}
  function automatic logic [2*IDX_W-1:0] index_pair(input logic [SIZE_W-1:0] a,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic rep);
    logic [SIZE_W-1:0] last;
    logic [SIZE_W-1:0] i0;
    logic [SIZE_W-1:0] i1;
    begin
      last = size - SIZE_W'(1);
      if (rep) begin
        i0 = a;
        i1 = (a == last) ? '0 : a + SIZE_W'(1);
      end else begin
        i0 = (a > last) ? last : a;
        i1 = (a >= last) ? last : a + SIZE_W'(1);
      end
      return {i0[IDX_W-1:0], i1[IDX_W-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bts_if.sv =====
// bilinear texture sampler: sample/write, result and configuration channels
// depends on bts_pkg
`default_nettype none
interface bts_in_if;
  import bts_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [COORD_W-1:0] coord_u;
  logic signed [COORD_W-1:0] coord_v;
  logic [1:0]                u_wrap;
  logic [1:0]                v_wrap;
  logic [15:0]               texel_index;
  logic [31:0]               texel_word;
  modport source (output valid, op, coord_u, coord_v, u_wrap, v_wrap, texel_index,
                  texel_word, input ready);
  modport sink   (input valid, op, coord_u, coord_v, u_wrap, v_wrap, texel_index,
                  texel_word, output ready);
endinterface

interface bts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface bts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bts_coord.sv =====
// coordinate stages: clamp/wrap, scale by texture size, texel indices and weights
// depends on bts_pkg, bts_if
`default_nettype none
module bts_coord
  import bts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  bts_in_if.sink                 in_ch,
  input  wire logic [SIZE_W-1:0] tex_width,
  input  wire logic [SIZE_W-1:0] tex_height,
  input  wire logic              layer_visible,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fetch_req_t             out_req
);

  logic en1, en2, en3;

  // stage 1
  logic              v1_r;
  kind_t             kind1_r, kind1_nxt;
  logic [OPND_W-1:0] mu1_r, mv1_r;
  logic [SIZE_W-1:0] w1_r, h1_r;
  logic              ru1_r, rv1_r;
  logic [ADDR_W-1:0] waddr1_r;
  logic [31:0]       wdata1_r;

  // stage 2
  logic              v2_r;
  kind_t             kind2_r;
  logic [POS_W-1:0]  pu2_r, pv2_r;
  logic [SIZE_W-1:0] w2_r, h2_r;
  logic              ru2_r, rv2_r;
  logic [ADDR_W-1:0] waddr2_r;
  logic [31:0]       wdata2_r;

  // stage 3
  logic              v3_r;
  fetch_req_t        req3_r, req3_nxt;
  logic [SIZE_W-1:0] w3_r, h3_r;

  logic [2*IDX_W-1:0] xp, yp;

  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  // no word is taken while reset holds the valid bits low
  assign in_ch.ready = en1 && rst_n;

  always_comb begin
    if (!in_ch.op) kind1_nxt = KIND_WRITE;
    else if (!layer_visible) kind1_nxt = KIND_HIDDEN;
    else if (outside_unit(in_ch.coord_u, in_ch.u_wrap) ||
             outside_unit(in_ch.coord_v, in_ch.v_wrap)) kind1_nxt = KIND_CLEAR;
    else kind1_nxt = KIND_SAMPLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
    if (en1) begin
      kind1_r  <= kind1_nxt;
      mu1_r    <= axis_operand(in_ch.coord_u, in_ch.u_wrap);
      mv1_r    <= axis_operand(in_ch.coord_v, in_ch.v_wrap);
      w1_r     <= eff_size(tex_width, SIZE_W'(MAX_WIDTH));
      h1_r     <= eff_size(tex_height, SIZE_W'(MAX_HEIGHT));
      ru1_r    <= (in_ch.u_wrap == WRAP_TILE);
      rv1_r    <= (in_ch.v_wrap == WRAP_TILE);
      waddr1_r <= in_ch.texel_index;
      wdata1_r <= in_ch.texel_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      kind2_r  <= kind1_r;
      pu2_r    <= POS_W'(mu1_r) * POS_W'(w1_r);
      pv2_r    <= POS_W'(mv1_r) * POS_W'(h1_r);
      w2_r     <= w1_r;
      h2_r     <= h1_r;
      ru2_r    <= ru1_r;
      rv2_r    <= rv1_r;
      waddr2_r <= waddr1_r;
      wdata2_r <= wdata1_r;
    end
  end

  assign xp = index_pair(pu2_r[COORD_FRAC_BITS +: SIZE_W], w2_r, ru2_r);
  assign yp = index_pair(pv2_r[COORD_FRAC_BITS +: SIZE_W], h2_r, rv2_r);

  always_comb begin
    req3_nxt.kind  = kind2_r;
    req3_nxt.x0    = xp[2*IDX_W-1:IDX_W];
    req3_nxt.x1    = xp[IDX_W-1:0];
    req3_nxt.y0    = yp[2*IDX_W-1:IDX_W];
    req3_nxt.y1    = yp[IDX_W-1:0];
    req3_nxt.fx    = pu2_r[COORD_FRAC_BITS-1 -: 8];
    req3_nxt.fy    = pv2_r[COORD_FRAC_BITS-1 -: 8];
    req3_nxt.waddr = waddr2_r;
    req3_nxt.wdata = wdata2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      req3_r <= req3_nxt;
      w3_r   <= w2_r;
      h3_r   <= h2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_req   = req3_r;

  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && req3_r.kind == KIND_SAMPLE |->
      SIZE_W'(req3_r.x0) < w3_r && SIZE_W'(req3_r.x1) < w3_r)
    else $error("column index beyond texture width");

  a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && req3_r.kind == KIND_SAMPLE |->
      SIZE_W'(req3_r.y0) < h3_r && SIZE_W'(req3_r.y1) < h3_r)
    else $error("row index beyond texture height");

  a_x_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && req3_r.kind == KIND_SAMPLE |->
      req3_r.x1 == req3_r.x0 + IDX_W'(1) || req3_r.x1 == req3_r.x0 || req3_r.x1 == '0)
    else $error("right texel is not a neighbor of the left one");

endmodule
`default_nettype wire

// ===== hdl/bts_fetch.sv =====
// texel store: four replicated copies, one per 2x2 corner, written together
// depends on bts_pkg
`default_nettype none
module bts_fetch
  import bts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire fetch_req_t in_req,
  output logic            out_valid,
  input  wire logic       out_ready,
  output blend_item_t     out_item
);

  logic              en4, wr_en, rd_en;
  logic              v4_r;
  kind_t             kind4_r;
  logic [7:0]        fx4_r, fy4_r;
  logic [ADDR_W-1:0] rd_addr [4];
  logic [31:0]       q_r [4];

  assign en4      = !v4_r || out_ready;
  assign in_ready = en4;
  assign wr_en    = en4 && in_valid && (in_req.kind == KIND_WRITE);
  assign rd_en    = en4 && in_valid && (in_req.kind != KIND_WRITE);

  // row * MAX_WIDTH + column
  assign rd_addr[0] = {in_req.y0, in_req.x0};
  assign rd_addr[1] = {in_req.y0, in_req.x1};
  assign rd_addr[2] = {in_req.y1, in_req.x0};
  assign rd_addr[3] = {in_req.y1, in_req.x1};

  for (genvar g = 0; g < 4; g++) begin : g_copy
    logic [31:0] mem [TEX_DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[in_req.waddr] <= in_req.wdata;
      end
      if (rd_en) begin
        q_r[g] <= mem[rd_addr[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= in_valid && (in_req.kind != KIND_WRITE);
    end
    if (en4) begin
      kind4_r <= in_req.kind;
      fx4_r   <= in_req.fx;
      fy4_r   <= in_req.fy;
    end
  end

  assign out_valid     = v4_r;
  assign out_item.kind = kind4_r;
  assign out_item.fx   = fx4_r;
  assign out_item.fy   = fy4_r;
  assign out_item.t00  = q_r[0];
  assign out_item.t10  = q_r[1];
  assign out_item.t01  = q_r[2];
  assign out_item.t11  = q_r[3];

endmodule
`default_nettype wire

// ===== hdl/bts_blend.sv =====
// bilinear blend: horizontal pass, vertical pass with rounding, result select
// depends on bts_pkg, bts_if
`default_nettype none
module bts_blend
  import bts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire blend_item_t in_item,
  input  wire logic [31:0] fallback_color,
  input  wire logic [2:0]  channel_count,
  bts_out_if.source        out_ch
);

  logic       en5, en6;
  logic       v5_r, v6_r;
  kind_t      kind5_r;
  logic [7:0] fy5_r;
  logic [15:0] h0_r [4];
  logic [15:0] h1_r [4];
  logic [15:0] h0_nxt [4];
  logic [15:0] h1_nxt [4];
  logic [8:0]  wx0, wx1, wy0, wy1;
  logic [7:0]  mix [4];
  logic [31:0] res_nxt, res_r;

  assign en6      = !v6_r || out_ch.ready;
  assign en5      = !v5_r || en6;
  assign in_ready = en5;

  assign wx1 = {1'b0, in_item.fx};
  assign wx0 = 9'd256 - wx1;
  assign wy1 = {1'b0, fy5_r};
  assign wy0 = 9'd256 - wy1;

  always_comb begin
    logic [16:0] p0, p1;
    for (int c = 0; c < 4; c++) begin
      p0 = 17'(in_item.t00[8*c +: 8]) * 17'(wx0) + 17'(in_item.t10[8*c +: 8]) * 17'(wx1);
      p1 = 17'(in_item.t01[8*c +: 8]) * 17'(wx0) + 17'(in_item.t11[8*c +: 8]) * 17'(wx1);
      h0_nxt[c] = p0[15:0];
      h1_nxt[c] = p1[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= in_valid;
    end
    if (en5) begin
      kind5_r <= in_item.kind;
      fy5_r   <= in_item.fy;
      h0_r    <= h0_nxt;
      h1_r    <= h1_nxt;
    end
  end

  always_comb begin
    logic [24:0] acc;
    for (int c = 0; c < 4; c++) begin
      acc = 25'(h0_r[c]) * 25'(wy0) + 25'(h1_r[c]) * 25'(wy1) + 25'd32768;
      mix[c] = acc[23:16];
    end
  end

  always_comb begin
    case (kind5_r)
      KIND_HIDDEN: res_nxt = fallback_color;
      KIND_SAMPLE: begin
        res_nxt = {mix[3], mix[2], mix[1], mix[0]};
        if (channel_count == CHANNELS_RGB) res_nxt[31:24] = 8'hff;
      end
      default:     res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= v5_r;
    end
    if (en6) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid = v6_r;
  assign out_ch.red   = res_r[7:0];
  assign out_ch.green = res_r[15:8];
  assign out_ch.blue  = res_r[23:16];
  assign out_ch.alpha = res_r[31:24];

endmodule
`default_nettype wire

// ===== hdl/bilinear_texture_sampler.sv =====
// bilinear texture sampler: a sample word is registered through the coordinate stages, the fetch and the blend passes
// throughput one word per cycle while the output is not stalled; texel writes and samples share the input channel
// the 2x2 fetch reads four copies of the texel store in the same cycle
// writes give no result; stalls at the output back up stage by stage, bubbles fill
// synchronous reset clears valid bits and sets configuration to defaults; texel store is not cleared
// depends on bts_pkg, bts_if, bts_coord, bts_fetch, bts_blend
`default_nettype none
module bilinear_texture_sampler
  import bts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  bts_in_if.sink    in_ch,
  bts_out_if.source out_ch,
  bts_cfg_if.sink   cfg_ch
);

  logic [SIZE_W-1:0] tex_width_r, tex_height_r;
  logic              layer_visible_r;
  logic [31:0]       fallback_color_r;
  logic [2:0]        channel_count_r;

  logic        crd_valid, crd_ready;
  fetch_req_t  crd_req;
  logic        fch_valid, fch_ready;
  blend_item_t fch_item;

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r      <= SIZE_W'(256);
      tex_height_r     <= SIZE_W'(256);
      layer_visible_r  <= 1'b1;
      fallback_color_r <= '0;
      channel_count_r  <= 3'd4;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WIDTH:    tex_width_r      <= cfg_ch.data[SIZE_W-1:0];
        REG_HEIGHT:   tex_height_r     <= cfg_ch.data[SIZE_W-1:0];
        REG_LAYER:    layer_visible_r  <= cfg_ch.data[0];
        REG_FALLBACK: fallback_color_r <= cfg_ch.data;
        REG_CHANNELS: channel_count_r  <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  bts_coord u_coord (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .tex_width     (tex_width_r),
    .tex_height    (tex_height_r),
    .layer_visible (layer_visible_r),
    .out_valid     (crd_valid),
    .out_ready     (crd_ready),
    .out_req       (crd_req)
  );

  bts_fetch u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (crd_valid),
    .in_ready  (crd_ready),
    .in_req    (crd_req),
    .out_valid (fch_valid),
    .out_ready (fch_ready),
    .out_item  (fch_item)
  );

  bts_blend u_blend (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (fch_valid),
    .in_ready       (fch_ready),
    .in_item        (fch_item),
    .fallback_color (fallback_color_r),
    .channel_count  (channel_count_r),
    .out_ch         (out_ch)
  );

  a_layer_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.index == REG_LAYER |=> layer_visible_r == $past(cfg_ch.data[0]))
    else $error("layer_visible not taken from configuration word");

  a_width_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.index == REG_WIDTH |=>
      tex_width_r == $past(cfg_ch.data[SIZE_W-1:0]))
    else $error("tex_width not taken from configuration word");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    crd_valid && crd_ready && crd_req.kind == KIND_WRITE |=> !fch_valid || $past(fch_valid))
    else $error("texel write produced a result word");

endmodule
`default_nettype wire
